// ===== sv/bwmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bwmm_pkg
// Shared types, constants and helpers of the bucketed window min/max tracker.
// ----------------------------------------------------------------------------
package bwmm_pkg;

  localparam int MAX_SLOTS_DEF = 64;
  localparam int MIN_SLOTS_DEF = 1;
  localparam int RESET_SLOTS   = 64;

  localparam int VALUE_W    = 16;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FIND_MAX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SLOTS = 2'd1;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam value_t SENT_FOR_MAX = -16'sd32767;
  localparam value_t SENT_FOR_MIN = 16'sd32767;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DELIVER
  } state_t;

  // per-cycle control for the head of the ring
  typedef struct packed {
    logic first;
    logic hit;
    logic in_window;
    logic is_tick;
    logic find_max;
  } scan_ctrl_t;

  function automatic value_t mode_sentinel(input logic find_max);
    mode_sentinel = find_max ? SENT_FOR_MAX : SENT_FOR_MIN;
  endfunction

endpackage

// ===== sv/bwmm_cell.sv =====
// ----------------------------------------------------------------------------
// bwmm_cell
// One slot of the ring: holds a slot extreme and passes it to its neighbor.
// ----------------------------------------------------------------------------
module bwmm_cell
  import bwmm_pkg::*;
(
  input  logic   clk,
  input  logic   clear,
  input  value_t clear_value,
  input  logic   shift,
  input  value_t data_in,
  output value_t data
);

  always_ff @(posedge clk) begin
    if (clear) begin
      data <= clear_value;
    end else if (shift) begin
      data <= data_in;
    end
  end

endmodule

// ===== sv/bwmm_scan.sv =====
// ----------------------------------------------------------------------------
// bwmm_scan
// Head of the ring: folds the item into its slot and tracks the running extreme.
// ----------------------------------------------------------------------------
module bwmm_scan
  import bwmm_pkg::*;
(
  input  logic       clk,
  input  logic       shift,
  input  scan_ctrl_t ctrl,
  input  value_t     head,
  input  value_t     sample,
  output value_t     fold,
  output value_t     best
);

  value_t sentinel;
  value_t base;
  value_t best_next;
  logic   better;

  assign sentinel = mode_sentinel(ctrl.find_max);

  always_comb begin
    fold = head;
    if (ctrl.hit) begin
      if (ctrl.is_tick) begin
        fold = sentinel;
      end else if (ctrl.find_max) begin
        fold = (sample > head) ? sample : head;
      end else begin
        fold = (sample < head) ? sample : head;
      end
    end
  end

  // accumulation restarts from the sentinel at the first slot of a pass
  always_comb begin
    base      = ctrl.first ? sentinel : best;
    better    = ctrl.find_max ? (fold > base) : (fold < base);
    best_next = (ctrl.in_window && better) ? fold : base;
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      best <= best_next;
    end
  end

endmodule

// ===== sv/bucketed_window_min_max_top.sv =====
// ----------------------------------------------------------------------------
// bucketed_window_min_max_top
// Min or max of a signed 16-bit signal over a ring of time slots.
// ----------------------------------------------------------------------------
//  channel  signals                                  direction
//  in       in_valid, in_ready, func, sample_value   item in
//  out      out_valid, out_ready, extreme_value      item out
//  cfg      cfg_wen, cfg_index, cfg_data             register write
//
//  The slots sit in a ring of MAX_SLOTS cells that turns one slot per cycle past
//  a head unit during a pass, so every item costs one full turn of the ring.
//  A sample is accepted, makes its turn and is handed off; a tick ends after its
//  turn; only then is a new item taken. The hand-off waits while the output
//  register is full and out_ready is low. rst (synchronous) or a find_max or
//  window_slots write sets all cells to the sentinel and the slot pointer to 0.
// ----------------------------------------------------------------------------
module bucketed_window_min_max_top
  import bwmm_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int MIN_SLOTS = MIN_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  value_t                sample_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output value_t                extreme_value
);

  localparam int PTR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST_K = PTR_W'(MAX_SLOTS - 1);

  function automatic logic [CNT_W-1:0] sat_slots(input int v);
    int s;
    s = v;
    if (s < MIN_SLOTS) s = MIN_SLOTS;
    if (s > MAX_SLOTS) s = MAX_SLOTS;
    sat_slots = CNT_W'(s);
  endfunction

  state_t state, state_next;

  logic             find_max;
  logic [CNT_W-1:0] window_slots;
  logic [PTR_W-1:0] cur_slot;
  logic [PTR_W-1:0] target;
  logic [PTR_W-1:0] tick_slot;
  logic [PTR_W-1:0] k;
  logic             is_tick;
  value_t           sample;

  logic       in_accept;
  logic       shift;
  logic       load_out;
  logic       reinit;
  value_t     clear_value;
  scan_ctrl_t ctrl;
  value_t     fold;
  value_t     best;
  value_t     cell_data [MAX_SLOTS];

  assign in_accept = in_valid && in_ready;
  assign reinit    = cfg_wen &&
                     (cfg_index == REG_FIND_MAX || cfg_index == REG_WINDOW_SLOTS);

  // sentinel of the mode that holds after this edge
  always_comb begin
    if (rst) begin
      clear_value = SENT_FOR_MAX;
    end else if (cfg_wen && cfg_index == REG_FIND_MAX) begin
      clear_value = mode_sentinel(cfg_data[0]);
    end else begin
      clear_value = mode_sentinel(find_max);
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      find_max     <= 1'b1;
      window_slots <= sat_slots(RESET_SLOTS);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_FIND_MAX:     find_max     <= cfg_data[0];
        REG_WINDOW_SLOTS: window_slots <= sat_slots(int'(cfg_data));
        default: ;
      endcase
    end
  end

  // next slot after a tick, wrapping at the slot count
  always_comb begin
    logic [CMP_W-1:0] inc;
    inc       = CMP_W'(cur_slot) + CMP_W'(1);
    tick_slot = (inc >= CMP_W'(window_slots)) ? '0 : inc[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      cur_slot <= '0;
    end else if (in_accept && func == FUNC_TICK) begin
      cur_slot <= tick_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      is_tick <= (func == FUNC_TICK);
      sample  <= sample_value;
      target  <= (func == FUNC_TICK) ? tick_slot : cur_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (in_accept) begin
      k <= '0;
    end else if (shift) begin
      k <= (k == LAST_K) ? '0 : k + PTR_W'(1);
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (k == LAST_K) state_next = is_tick ? ST_IDLE : ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    shift    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_SCAN:    shift    = 1'b1;
      ST_DELIVER: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  // ring of cells, the head is cell 0 and the folded slot re-enters at the tail
  assign ctrl.first     = (k == '0);
  assign ctrl.hit       = (k == target);
  assign ctrl.in_window = CMP_W'(k) < CMP_W'(window_slots);
  assign ctrl.is_tick   = is_tick;
  assign ctrl.find_max  = find_max;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    value_t next_in;
    if (i == MAX_SLOTS - 1) begin : g_tail
      assign next_in = fold;
    end else begin : g_mid
      assign next_in = cell_data[i+1];
    end
    bwmm_cell u_cell (
      .clk         (clk),
      .clear       (rst || reinit),
      .clear_value (clear_value),
      .shift       (shift),
      .data_in     (next_in),
      .data        (cell_data[i])
    );
  end

  bwmm_scan u_scan (
    .clk    (clk),
    .shift  (shift),
    .ctrl   (ctrl),
    .head   (cell_data[0]),
    .sample (sample),
    .fold   (fold),
    .best   (best)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      extreme_value <= best;
    end
  end

  a_cur_in_window: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(cur_slot) < CMP_W'(window_slots))
    else $error("slot pointer outside the window");

  a_target_in_window: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CMP_W'(target) < CMP_W'(window_slots))
    else $error("target slot outside the window");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_SCAN && k == '0)
    else $error("accepted item did not start a pass");

  a_result_after_pass: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DELIVER) && !$past(is_tick))
    else $error("result without a finished sample pass");

  a_window_bounds: assert property (@(posedge clk) disable iff (rst)
    window_slots != '0 && int'(window_slots) <= MAX_SLOTS)
    else $error("slot count out of range");

endmodule
